// ----- rtl/sbam_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbam_pkg
// Shared types, constants and the stencil segment table of the band mapper.
// ----------------------------------------------------------------------------
package sbam_pkg;

    localparam int MAX_GRID_SIDE = 256;
    localparam int MAX_UNKNOWNS  = 8;
    localparam int DIV_W         = 28;
    localparam int SEG_COUNT     = 21;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_GRID_X   = 3'd0,
        REG_GRID_Y   = 3'd1,
        REG_GRID_Z   = 3'd2,
        REG_UNKNOWNS = 3'd3,
        REG_DIMS     = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        DIV_ROW_DOF,
        DIV_COL_DOF,
        DIV_PLANE,
        DIV_LINE,
        DIV_ROW_TOTAL
    } t_div_sel;

    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_POS,
        BASE_NEG
    } t_base;

    typedef enum logic [1:0] {
        KIND_SINGLE,
        KIND_PLUS,
        KIND_MINUS
    } t_kind;

    // One run of the displacement table: x = base +/- i, fixed y and z
    typedef struct packed {
        t_base             base;
        t_kind             kind;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
        logic [1:0]        min_dim;
    } t_seg;

    typedef struct packed {
        logic     mul_line;
        logic     mul_plane;
        logic     mul_total;
        logic     div_start;
        t_div_sel div_sel;
        logic     calc_c;
        logic     walk_init;
        logic     walk_step;
        logic     addr;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic walk_done;
    } t_stat;

    function automatic t_seg seg_info(input logic [4:0] s);
        t_seg r;
        case (s)
            5'd0:  r = '{BASE_ZERO, KIND_SINGLE,  2'sd0,  2'sd0, 2'd0};
            5'd1:  r = '{BASE_ZERO, KIND_PLUS,    2'sd0,  2'sd0, 2'd0};
            5'd2:  r = '{BASE_POS,  KIND_SINGLE,  2'sd0,  2'sd0, 2'd1};
            5'd3:  r = '{BASE_POS,  KIND_PLUS,    2'sd0,  2'sd0, 2'd1};
            5'd4:  r = '{BASE_POS,  KIND_MINUS,   2'sd0,  2'sd0, 2'd1};
            5'd5:  r = '{BASE_ZERO, KIND_SINGLE,  2'sd1,  2'sd0, 2'd2};
            5'd6:  r = '{BASE_ZERO, KIND_PLUS,    2'sd1,  2'sd0, 2'd2};
            5'd7:  r = '{BASE_ZERO, KIND_MINUS,   2'sd1,  2'sd0, 2'd2};
            5'd8:  r = '{BASE_ZERO, KIND_SINGLE,  2'sd0,  2'sd1, 2'd3};
            5'd9:  r = '{BASE_ZERO, KIND_PLUS,    2'sd0,  2'sd1, 2'd3};
            5'd10: r = '{BASE_ZERO, KIND_MINUS,   2'sd0,  2'sd1, 2'd3};
            5'd11: r = '{BASE_ZERO, KIND_MINUS,   2'sd0,  2'sd0, 2'd0};
            5'd12: r = '{BASE_NEG,  KIND_SINGLE,  2'sd0,  2'sd0, 2'd1};
            5'd13: r = '{BASE_NEG,  KIND_PLUS,    2'sd0,  2'sd0, 2'd1};
            5'd14: r = '{BASE_NEG,  KIND_MINUS,   2'sd0,  2'sd0, 2'd1};
            5'd15: r = '{BASE_ZERO, KIND_SINGLE, -2'sd1,  2'sd0, 2'd2};
            5'd16: r = '{BASE_ZERO, KIND_PLUS,   -2'sd1,  2'sd0, 2'd2};
            5'd17: r = '{BASE_ZERO, KIND_MINUS,  -2'sd1,  2'sd0, 2'd2};
            5'd18: r = '{BASE_ZERO, KIND_SINGLE,  2'sd0, -2'sd1, 2'd3};
            5'd19: r = '{BASE_ZERO, KIND_PLUS,    2'sd0, -2'sd1, 2'd3};
            5'd20: r = '{BASE_ZERO, KIND_MINUS,   2'sd0, -2'sd1, 2'd3};
            default: r = '{BASE_ZERO, KIND_SINGLE, 2'sd0, 2'sd0, 2'd0};
        endcase
        return r;
    endfunction

    // Zero reads as one, oversize saturates
    function automatic logic [8:0] eff_side(input logic [8:0] v);
        logic [8:0] r;
        if (v == 9'd0) begin
            r = 9'd1;
        end else if (v > 9'(MAX_GRID_SIDE)) begin
            r = 9'(MAX_GRID_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [3:0] eff_dof(input logic [3:0] v);
        logic [3:0] r;
        if (v == 4'd0) begin
            r = 4'd1;
        end else if (v > 4'(MAX_UNKNOWNS)) begin
            r = 4'(MAX_UNKNOWNS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/stencil_band_address_mapper_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stencil_band_address_mapper_unit
// Maps a matrix entry (row, column) to its band and slot in a band store.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Payload
// s_axis    in   i_s_axis_tvalid/o_..ready tdata: row_index, col_index
// m_axis    out  o_m_axis_tvalid/i_..ready tdata: band_index, store_address;
//                                          tuser: hit
// apb       in   psel/penable/pwrite       registers grid_x..dimensions
//
// One transaction makes five runs of the shared 28-step divider (row and
// column mod unknowns, plane split, line split, row mod grid points times
// unknowns), which set most of its length, then walks the stencil table
// entries and empty table segments until the first match or the table end.
// A new transaction is taken only when idle.
// Reset is synchronous and active low; it returns the registers to a 1x1x1
// grid, one unknown, three dimensions. The result sits in an output register,
// so a stalled master side holds the result while the next input is taken.
// ----------------------------------------------------------------------------
module stencil_band_address_mapper_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // row_index [26:0], col_index [53:27], zeros above
    input  logic [55:0] i_s_axis_tdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // band_index [6:0], store_address [40:7], zeros above
    output logic [47:0] o_m_axis_tdata,
    // hit [0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // Configuration registers
    logic [8:0] r_grid_x, r_grid_y, r_grid_z;
    logic [3:0] r_unknowns;
    logic [1:0] r_dims;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_x   <= 9'd1;
            r_grid_y   <= 9'd1;
            r_grid_z   <= 9'd1;
            r_unknowns <= 4'd1;
            r_dims     <= 2'd3;
        end else if (w_wr) begin
            case (paddr[4:2])
                sbam_pkg::REG_GRID_X:   r_grid_x   <= pwdata[8:0];
                sbam_pkg::REG_GRID_Y:   r_grid_y   <= pwdata[8:0];
                sbam_pkg::REG_GRID_Z:   r_grid_z   <= pwdata[8:0];
                sbam_pkg::REG_UNKNOWNS: r_unknowns <= pwdata[3:0];
                sbam_pkg::REG_DIMS:     r_dims     <= pwdata[1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            sbam_pkg::REG_GRID_X:   prdata = {23'd0, r_grid_x};
            sbam_pkg::REG_GRID_Y:   prdata = {23'd0, r_grid_y};
            sbam_pkg::REG_GRID_Z:   prdata = {23'd0, r_grid_z};
            sbam_pkg::REG_UNKNOWNS: prdata = {28'd0, r_unknowns};
            sbam_pkg::REG_DIMS:     prdata = {30'd0, r_dims};
            default:                prdata = 32'd0;
        endcase
    end

    // Controller and datapath
    sbam_pkg::t_cmd  w_cmd;
    sbam_pkg::t_stat w_stat;
    logic            w_idle, w_accept, w_out_free;
    logic            w_hit;
    logic [6:0]      w_band;
    logic [33:0]     w_addr;

    assign o_s_axis_tready = w_idle;
    assign w_accept        = i_s_axis_tvalid & w_idle;

    sbam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle)
    );

    sbam_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_row      (i_s_axis_tdata[26:0]),
        .i_col      (i_s_axis_tdata[53:27]),
        .i_grid_x   (r_grid_x),
        .i_grid_y   (r_grid_y),
        .i_grid_z   (r_grid_z),
        .i_unknowns (r_unknowns),
        .i_dims     (r_dims),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_hit      (w_hit),
        .o_band     (w_band),
        .o_addr     (w_addr)
    );

    // Output register: hold the result until the master side takes it
    logic        r_out_valid;
    logic        r_out_hit;
    logic [6:0]  r_out_band;
    logic [33:0] r_out_addr;

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out_hit  <= w_hit;
            r_out_band <= w_band;
            r_out_addr <= w_addr;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_hit;
    assign o_m_axis_tdata  = {7'd0, r_out_addr, r_out_band};

endmodule

// ----- rtl/sbam_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbam_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbam_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sbam_pkg::DIV_W-1:0]    i_dividend,
    input  logic [sbam_pkg::DIV_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [sbam_pkg::DIV_W-1:0]    o_quotient,
    output logic [sbam_pkg::DIV_W-1:0]    o_remainder
);
    localparam int W = sbam_pkg::DIV_W;

    logic         r_busy;
    logic         r_done;
    logic [4:0]   r_cnt;
    logic [W-1:0] r_quo;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_dvs;
    logic [W:0]   w_sh;
    logic [W:0]   w_diff;

    assign w_sh   = {r_rem, r_quo[W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // flag the last quotient step
            r_done <= r_busy && !i_start && (r_cnt == 5'(W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == 5'(W - 1)) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                r_rem <= w_diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- rtl/sbam_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbam_datapath
// Size products, displacement split, table walk and address product.
// ----------------------------------------------------------------------------
module sbam_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [26:0]          i_row,
    input  logic [26:0]          i_col,
    input  logic [8:0]           i_grid_x,
    input  logic [8:0]           i_grid_y,
    input  logic [8:0]           i_grid_z,
    input  logic [3:0]           i_unknowns,
    input  logic [1:0]           i_dims,
    input  sbam_pkg::t_cmd       i_cmd,
    output sbam_pkg::t_stat      o_stat,
    output logic                 o_hit,
    output logic [6:0]           o_band,
    output logic [33:0]          o_addr
);
    localparam int W = sbam_pkg::DIV_W;

    logic [26:0] r_row, r_col;
    logic [8:0]  r_m, r_n, r_p;
    logic [3:0]  r_d;
    logic [1:0]  r_dim;
    logic [11:0] r_line;
    logic [19:0] r_plane;
    logic [27:0] r_total;
    logic [2:0]  r_rsh, r_csh;
    logic        r_neg;
    logic [27:0] r_cmag;
    logic [27:0] r_zq, r_yq;
    logic [19:0] r_rem1;
    logic signed [13:0] r_xd;
    logic [26:0] r_rowm;
    sbam_pkg::t_div_sel r_sel;

    logic [4:0]  r_seg;
    logic [2:0]  r_i;
    logic [6:0]  r_k;
    logic        r_found, r_end;
    logic        r_hit;
    logic [6:0]  r_band;
    logic [33:0] r_addr;

    logic [W-1:0] w_dividend, w_divisor, w_quo, w_rem;
    logic         w_done;

    sbam_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_comb begin
        case (i_cmd.div_sel)
            sbam_pkg::DIV_ROW_DOF: begin
                w_dividend = {1'b0, r_row};
                w_divisor  = {24'd0, r_d};
            end
            sbam_pkg::DIV_COL_DOF: begin
                w_dividend = {1'b0, r_col};
                w_divisor  = {24'd0, r_d};
            end
            sbam_pkg::DIV_PLANE: begin
                w_dividend = r_cmag;
                w_divisor  = {8'd0, r_plane};
            end
            sbam_pkg::DIV_LINE: begin
                w_dividend = {8'd0, r_rem1};
                w_divisor  = {16'd0, r_line};
            end
            sbam_pkg::DIV_ROW_TOTAL: begin
                w_dividend = {1'b0, r_row};
                w_divisor  = r_total;
            end
            default: begin
                w_dividend = '0;
                w_divisor  = 28'd1;
            end
        endcase
    end

    // Products and the signed displacement
    logic [12:0]        w_line;
    logic [20:0]        w_plane;
    logic [28:0]        w_total;
    logic signed [29:0] w_c, w_cabs;
    logic signed [13:0] w_r2, w_xd;
    logic [34:0]        w_addr;

    assign w_line  = 13'(r_m) * 13'(r_d);
    assign w_plane = 21'(r_line) * 21'(r_n);
    assign w_total = 29'(r_plane) * 29'(r_p);
    assign w_c     = $signed({3'd0, r_col}) - $signed({3'd0, r_row})
                   + $signed({27'd0, r_rsh}) - $signed({27'd0, r_csh});
    assign w_cabs  = w_c[29] ? (30'sd0 - w_c) : w_c;
    assign w_r2    = $signed({3'd0, w_rem[10:0]});
    assign w_xd    = (r_neg ? (14'sd0 - w_r2) : w_r2)
                   + $signed({11'd0, r_csh}) - $signed({11'd0, r_rsh});
    assign w_addr  = 35'(r_k) * 35'(r_total) + 35'(r_rowm);

    // Table walk: current entry
    sbam_pkg::t_seg     w_seg;
    logic               w_en, w_mx, w_my, w_mz, w_last;
    logic signed [5:0]  w_base, w_off, w_dx;

    function automatic logic q_match(input logic signed [1:0] code,
                                     input logic [27:0] q, input logic neg);
        logic r;
        if (code == 2'sd0) begin
            r = (q == 28'd0);
        end else begin
            r = (q == 28'd1) && (neg == code[1]);
        end
        return r;
    endfunction

    always_comb begin
        w_seg = sbam_pkg::seg_info(r_seg);
        w_en  = (r_dim >= w_seg.min_dim) &&
                ((w_seg.kind == sbam_pkg::KIND_SINGLE) || (r_d > 4'd1));
        case (w_seg.base)
            sbam_pkg::BASE_POS: w_base = $signed({2'd0, r_d});
            sbam_pkg::BASE_NEG: w_base = 6'sd0 - $signed({2'd0, r_d});
            default:            w_base = 6'sd0;
        endcase
        case (w_seg.kind)
            sbam_pkg::KIND_PLUS:  w_off = $signed({3'd0, r_i});
            sbam_pkg::KIND_MINUS: w_off = 6'sd0 - $signed({3'd0, r_i});
            default:              w_off = 6'sd0;
        endcase
        w_dx   = w_base + w_off;
        w_mx   = (14'(w_dx) == r_xd);
        w_my   = q_match(w_seg.dy, r_yq, r_neg);
        w_mz   = q_match(w_seg.dz, r_zq, r_neg);
        w_last = ({1'b0, r_i} == (r_d - 4'd1));
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row <= i_row;
            r_col <= i_col;
            r_m   <= sbam_pkg::eff_side(i_grid_x);
            r_n   <= sbam_pkg::eff_side(i_grid_y);
            r_p   <= sbam_pkg::eff_side(i_grid_z);
            r_d   <= sbam_pkg::eff_dof(i_unknowns);
            r_dim <= i_dims;
        end
        if (i_cmd.mul_line)  r_line  <= w_line[11:0];
        if (i_cmd.mul_plane) r_plane <= w_plane[19:0];
        if (i_cmd.mul_total) r_total <= w_total[27:0];
        if (i_cmd.div_start) r_sel   <= i_cmd.div_sel;
        if (i_cmd.calc_c) begin
            r_neg  <= w_c[29];
            r_cmag <= w_cabs[27:0];
        end
        if (w_done) begin
            case (r_sel)
                sbam_pkg::DIV_ROW_DOF: r_rsh <= w_rem[2:0];
                sbam_pkg::DIV_COL_DOF: r_csh <= w_rem[2:0];
                sbam_pkg::DIV_PLANE: begin
                    r_zq   <= w_quo;
                    r_rem1 <= w_rem[19:0];
                end
                sbam_pkg::DIV_LINE: begin
                    r_yq <= w_quo;
                    r_xd <= w_xd;
                end
                sbam_pkg::DIV_ROW_TOTAL: r_rowm <= w_rem[26:0];
                default: ;
            endcase
        end
        if (i_cmd.addr) begin
            r_hit  <= r_found;
            r_band <= r_found ? r_k : 7'd0;
            r_addr <= r_found ? w_addr[33:0] : 34'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg   <= '0;
            r_i     <= 3'd1;
            r_k     <= '0;
            r_found <= 1'b0;
            r_end   <= 1'b0;
        end else if (i_cmd.walk_init) begin
            r_seg   <= '0;
            r_i     <= 3'd1;
            r_k     <= '0;
            r_found <= 1'b0;
            r_end   <= 1'b0;
        end else if (i_cmd.walk_step && !r_found && !r_end) begin
            if (r_seg == 5'(sbam_pkg::SEG_COUNT)) begin
                r_end <= 1'b1;
            end else if (!w_en) begin
                r_seg <= r_seg + 5'd1;
                r_i   <= 3'd1;
            end else if (w_mx && w_my && w_mz) begin
                r_found <= 1'b1;
            end else begin
                r_k <= r_k + 7'd1;
                if ((w_seg.kind == sbam_pkg::KIND_SINGLE) || w_last) begin
                    r_seg <= r_seg + 5'd1;
                    r_i   <= 3'd1;
                end else begin
                    r_i <= r_i + 3'd1;
                end
            end
        end
    end

    assign o_stat.div_done  = w_done;
    assign o_stat.walk_done = r_found | r_end;
    assign o_hit  = r_hit;
    assign o_band = r_band;
    assign o_addr = r_addr;

endmodule

// ----- rtl/sbam_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbam_ctrl
// Sequencer for one transaction: products, five divisions, walk, address.
// ----------------------------------------------------------------------------
module sbam_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_out_free,
    input  sbam_pkg::t_stat  i_stat,
    output sbam_pkg::t_cmd   o_cmd,
    output logic             o_idle
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_LINE,
        S_PLANE,
        S_TOTAL,
        S_W_ROW,
        S_W_COL,
        S_CALC,
        S_W_Z,
        S_W_Y,
        S_W_RT,
        S_WINIT,
        S_WALK,
        S_ADDR,
        S_OUT
    } t_state;

    t_state          r_state;
    sbam_pkg::t_cmd  r_cmd;

    always_ff @(posedge i_clk) begin
        sbam_pkg::t_cmd n_cmd;
        n_cmd = '0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_state        <= S_LINE;
                        n_cmd.mul_line = 1'b1;
                    end
                end
                S_LINE: begin
                    r_state         <= S_PLANE;
                    n_cmd.mul_plane = 1'b1;
                end
                S_PLANE: begin
                    r_state         <= S_TOTAL;
                    n_cmd.mul_total = 1'b1;
                end
                S_TOTAL: begin
                    r_state         <= S_W_ROW;
                    n_cmd.div_start = 1'b1;
                    n_cmd.div_sel   = sbam_pkg::DIV_ROW_DOF;
                end
                S_W_ROW: begin
                    if (i_stat.div_done) begin
                        r_state         <= S_W_COL;
                        n_cmd.div_start = 1'b1;
                        n_cmd.div_sel   = sbam_pkg::DIV_COL_DOF;
                    end
                end
                S_W_COL: begin
                    if (i_stat.div_done) begin
                        r_state      <= S_CALC;
                        n_cmd.calc_c = 1'b1;
                    end
                end
                S_CALC: begin
                    r_state         <= S_W_Z;
                    n_cmd.div_start = 1'b1;
                    n_cmd.div_sel   = sbam_pkg::DIV_PLANE;
                end
                S_W_Z: begin
                    if (i_stat.div_done) begin
                        r_state         <= S_W_Y;
                        n_cmd.div_start = 1'b1;
                        n_cmd.div_sel   = sbam_pkg::DIV_LINE;
                    end
                end
                S_W_Y: begin
                    if (i_stat.div_done) begin
                        r_state         <= S_W_RT;
                        n_cmd.div_start = 1'b1;
                        n_cmd.div_sel   = sbam_pkg::DIV_ROW_TOTAL;
                    end
                end
                S_W_RT: begin
                    if (i_stat.div_done) begin
                        r_state         <= S_WINIT;
                        n_cmd.walk_init = 1'b1;
                    end
                end
                S_WINIT: begin
                    r_state         <= S_WALK;
                    n_cmd.walk_step = 1'b1;
                end
                S_WALK: begin
                    if (i_stat.walk_done) begin
                        r_state    <= S_ADDR;
                        n_cmd.addr = 1'b1;
                    end else begin
                        n_cmd.walk_step = 1'b1;
                    end
                end
                S_ADDR: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_free) begin
                        r_state        <= S_IDLE;
                        n_cmd.out_load = 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd  = r_cmd;
    assign o_idle = (r_state == S_IDLE);

endmodule

// ----- sim/stencil_band_address_mapper_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stencil_band_address_mapper_unit_tb
// Drives (row, column) pairs into the band mapper under several grid setups,
// predicts band and store address from its own displacement table, and
// compares every result under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module stencil_band_address_mapper_unit_tb;

    typedef struct {
        logic [26:0] row;
        logic [26:0] col;
    } t_entry;

    typedef struct {
        logic        hit;
        logic [6:0]  band;
        logic [33:0] addr;
    } t_slot;

    logic        i_clk;
    logic        i_rst_n;
    logic [55:0] i_s_axis_tdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [47:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    stencil_band_address_mapper_unit u_top (.*);

    // Predictor state: shadow registers and displacement table
    logic [8:0] sh_gx, sh_gy, sh_gz;
    logic [3:0] sh_dof;
    logic [1:0] sh_dims;
    int         disp_x[$], disp_y[$], disp_z[$];

    t_entry pending_entries[$];
    t_slot  expected_slots[$];

    int  errors = 0;
    int  results_seen = 0;
    int  hits_seen = 0;
    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    bit  hold_sink = 0;
    int  hold_cycles = 0;
    longint cycle_count = 0;
    localparam longint CYCLE_LIMIT = 4000000;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Abort on a runaway simulation
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("stencil_band_address_mapper_unit_tb failed");
            $finish;
        end
    end

    function automatic void push_disp(int x, int y, int z);
        if (disp_x.size() < 105) begin
            disp_x.push_back(x); disp_y.push_back(y); disp_z.push_back(z);
        end
    endfunction

    function automatic void push_disp_group(int d, int y, int z);
        push_disp(0, y, z);
        for (int i = 1; i < d; i++) push_disp(i, y, z);
        for (int i = 1; i < d; i++) push_disp(-i, y, z);
    endfunction

    // Rebuild the table in stencil order whenever dof or dims change
    function automatic void rebuild_disp_table();
        int d;
        d = (sh_dof == 0) ? 1 : (sh_dof > 8) ? 8 : int'(sh_dof);
        disp_x.delete(); disp_y.delete(); disp_z.delete();
        push_disp(0, 0, 0);
        for (int i = 1; i < d; i++) push_disp(i, 0, 0);
        if (sh_dims > 0) begin
            push_disp(d, 0, 0);
            for (int i = 1; i < d; i++) push_disp(d + i, 0, 0);
            for (int i = 1; i < d; i++) push_disp(d - i, 0, 0);
        end
        if (sh_dims > 1) push_disp_group(d, 1, 0);
        if (sh_dims > 2) push_disp_group(d, 0, 1);
        for (int i = 1; i < d; i++) push_disp(-i, 0, 0);
        if (sh_dims > 0) begin
            push_disp(-d, 0, 0);
            for (int i = 1; i < d; i++) push_disp(-d + i, 0, 0);
            for (int i = 1; i < d; i++) push_disp(-d - i, 0, 0);
        end
        if (sh_dims > 1) push_disp_group(d, -1, 0);
        if (sh_dims > 2) push_disp_group(d, 0, -1);
    endfunction

    function automatic longint side_of(logic [8:0] v);
        return (v == 0) ? 1 : (v > 256) ? 256 : longint'(v);
    endfunction

    function automatic t_slot map_entry(t_entry e);
        t_slot  s;
        longint row, col, m, n, p, d, line, plane, total, rsh, csh, c, zd, yd, xd;
        s = '{1'b0, 7'd0, 34'd0};
        row = e.row; col = e.col;
        m = side_of(sh_gx); n = side_of(sh_gy); p = side_of(sh_gz);
        d = (sh_dof == 0) ? 1 : (sh_dof > 8) ? 8 : longint'(sh_dof);
        line = m * d; plane = m * n * d; total = plane * p;
        rsh = row % d; csh = col % d;
        c = (col - row) + rsh - csh;
        zd = c / plane; c = c % plane;
        yd = c / line;  c = c % line;
        xd = c + csh - rsh;
        foreach (disp_x[k]) begin
            if (disp_x[k] == xd && disp_y[k] == yd && disp_z[k] == zd) begin
                s.hit  = 1'b1;
                s.band = 7'(k);
                s.addr = 34'(longint'(k) * total + row % total);
                break;
            end
        end
        return s;
    endfunction

    // Driver: offer the head of the queue, drop it once accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_slots.push_back(map_entry(pending_entries.pop_front()));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_entries.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {2'b0, pending_entries[0].col, pending_entries[0].row};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_slot x;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                if (expected_slots.size() == 0) begin
                    $display("%0t: unexpected result hit=%0b band=%0d addr=%0d", $time,
                             o_m_axis_tuser, o_m_axis_tdata[6:0], o_m_axis_tdata[40:7]);
                    errors++;
                end else begin
                    x = expected_slots.pop_front();
                    if (x.hit) hits_seen++;
                    if (o_m_axis_tuser !== x.hit) begin
                        $display("%0t: hit expected %0b actual %0b", $time, x.hit,
                                 o_m_axis_tuser);
                        errors++;
                    end
                    if (o_m_axis_tdata[6:0] !== x.band) begin
                        $display("%0t: band expected %0d actual %0d", $time, x.band,
                                 o_m_axis_tdata[6:0]);
                        errors++;
                    end
                    if (o_m_axis_tdata[40:7] !== x.addr) begin
                        $display("%0t: address expected %0d actual %0d", $time, x.addr,
                                 o_m_axis_tdata[40:7]);
                        errors++;
                    end
                end
            end
            i_m_axis_tready <= !hold_sink && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Long sink hold-off, counted in its own process
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            hold_sink   <= 1'b1;
        end else begin
            hold_sink   <= 1'b0;
        end
    end

    task automatic apb_write(sbam_pkg::t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            sbam_pkg::REG_GRID_X:   sh_gx = val[8:0];
            sbam_pkg::REG_GRID_Y:   sh_gy = val[8:0];
            sbam_pkg::REG_GRID_Z:   sh_gz = val[8:0];
            sbam_pkg::REG_UNKNOWNS: begin sh_dof = val[3:0]; rebuild_disp_table(); end
            sbam_pkg::REG_DIMS:     begin sh_dims = val[1:0]; rebuild_disp_table(); end
            default: ;
        endcase
    endtask

    // Wait until every queued item has been mapped and checked
    task automatic drain();
        while (pending_entries.size() > 0 || expected_slots.size() > 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_grid(int gx, int gy, int gz, int dof, int dims);
        apb_write(sbam_pkg::REG_GRID_X, gx);
        apb_write(sbam_pkg::REG_GRID_Y, gy);
        apb_write(sbam_pkg::REG_GRID_Z, gz);
        apb_write(sbam_pkg::REG_UNKNOWNS, dof);
        apb_write(sbam_pkg::REG_DIMS, dims);
    endtask

    // Build a pair that usually lands on a stencil neighbour of row
    function automatic t_entry near_entry();
        t_entry e;
        longint m, n, p, d, total, row, col, dz, dy, dx;
        m = side_of(sh_gx); n = side_of(sh_gy); p = side_of(sh_gz);
        d = (sh_dof == 0) ? 1 : (sh_dof > 8) ? 8 : longint'(sh_dof);
        total = m * n * p * d;
        row = $urandom_range(0, 32'(total - 1));
        dz = $urandom_range(0, 2) - 1; dy = $urandom_range(0, 2) - 1;
        dx = $urandom_range(0, 32'(4 * d)) - 2 * d;
        col = row + dz * m * n * d + dy * m * d + dx;
        if (col < 0) col = 0;
        if (col > 134217727) col = 134217727;
        e.row = 27'(row); e.col = 27'(col);
        return e;
    endfunction

    task automatic random_phase(int count);
        t_entry e;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 80) begin
                e = near_entry();
            end else begin
                e.row = 27'($urandom); e.col = 27'($urandom);
            end
            pending_entries.push_back(e);
        end
        drain();
    endtask

    initial begin
        t_entry e;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0; i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        sh_gx = 1; sh_gy = 1; sh_gz = 1; sh_dof = 1; sh_dims = 3;
        rebuild_disp_table();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: reset setup, field extremes, misses, out-of-range rows
        pending_entries.push_back('{27'd0, 27'd0});
        pending_entries.push_back('{27'h7FFFFFF, 27'h7FFFFFF});
        pending_entries.push_back('{27'd0, 27'h7FFFFFF});
        pending_entries.push_back('{27'h7FFFFFF, 27'd0});
        drain();
        set_grid(4, 3, 2, 2, 3);
        pending_entries.push_back('{27'd20, 27'd20});
        pending_entries.push_back('{27'd20, 27'd21});
        pending_entries.push_back('{27'd20, 27'd22});
        pending_entries.push_back('{27'd20, 27'd28});
        pending_entries.push_back('{27'd30, 27'd6});
        pending_entries.push_back('{27'd25, 27'd24});
        pending_entries.push_back('{27'd100, 27'd101});
        pending_entries.push_back('{27'd5, 27'd90});
        drain();
        // Zero values read as one, oversize saturates
        set_grid(0, 511, 0, 0, 0);
        pending_entries.push_back('{27'd3, 27'd3});
        pending_entries.push_back('{27'd3, 27'd4});
        pending_entries.push_back('{27'd600, 27'd856});
        drain();
        set_grid(256, 256, 256, 15, 3);
        pending_entries.push_back('{27'h5555555, 27'h5555555});
        pending_entries.push_back('{27'h2AAAAAA, 27'h2AAAAAB});
        pending_entries.push_back('{27'd9, 27'd0});
        drain();

        // Random phases across setups and idle profiles
        set_grid(5, 4, 3, 3, 3);
        src_idle_pct = 0; sink_stall_pct = 0;
        random_phase(190);
        set_grid(1, 7, 2, 8, 2);
        src_idle_pct = 48; sink_stall_pct = 0;
        random_phase(180);
        set_grid(256, 256, 256, 1, 1);
        src_idle_pct = 0; sink_stall_pct = 48;
        for (int i = 0; i < 40; i++) begin
            e = near_entry(); pending_entries.push_back(e);
        end
        hold_cycles = 3000;
        drain();
        set_grid(9, 2, 6, 4, 3);
        random_phase(150);
        set_grid(3, 3, 3, 2, 0);
        src_idle_pct = 27; sink_stall_pct = 27;
        random_phase(180);

        $display("checked %0d results (%0d hits) over grid, dof and dimension setups",
                 results_seen, hits_seen);
        if (errors == 0) begin
            $display("stencil_band_address_mapper_unit_tb passed");
        end else begin
            $display("stencil_band_address_mapper_unit_tb failed");
        end
        $finish;
    end

endmodule
